@@ design/rmf_pkg.sv @@
// shared types for the running median filter
// control commands, status and controller state codes; no dependencies
package rmf_pkg;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } rmf_state_e;

  typedef struct packed {
    logic wr_en;    // store the new sample and restart the rank scan
    logic scan_en;  // rank one window entry this cycle
    logic publish;  // move the found median into the output register
  } rmf_cmd_t;

  typedef struct packed {
    logic scan_last;  // the entry being ranked is the last one
  } rmf_sts_t;

endpackage

@@ design/rmf_stream_if.sv @@
// valid/ready channels for the running median filter
// sample request in, median request out; no dependencies
interface rmf_sample_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rmf_median_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

@@ design/running_median_filter_unit.sv @@
// running median filter: median of the last WINDOW signed samples per request
// an accepted sample is stored, then the window is rank-scanned, one window
//   entry per cycle against all others, then the median is registered when the
//   output is free; a new request is taken only once the filter is idle again
// reset: window store and write slot cleared to zero, no output pending
module running_median_filter_unit #(
  parameter int unsigned WINDOW      = 11,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  rmf_sample_if.sink  in_i,
  rmf_median_if.source out_o
);
  import rmf_pkg::*;

  rmf_cmd_t cmd;
  rmf_sts_t sts;

  rmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rmf_datapath #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .sample_i (in_i.sample),
    .median_o (out_o.median)
  );

endmodule

@@ design/rmf_ctrl.sv @@
// controller state machine of the running median filter
// sequences store, rank scan and output; uses rmf_pkg
module rmf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rmf_pkg::rmf_sts_t sts_i,
  output rmf_pkg::rmf_cmd_t cmd_o
);
  import rmf_pkg::*;

  rmf_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.wr_en = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ design/rmf_datapath.sv @@
// datapath of the running median filter: window store, rank counter, output register
// one entry is ranked against all others per cycle; uses rmf_pkg
module rmf_datapath #(
  parameter int unsigned WINDOW      = 11,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rmf_pkg::rmf_cmd_t             cmd_i,
  output rmf_pkg::rmf_sts_t             sts_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] median_o
);
  import rmf_pkg::*;

  localparam int unsigned IdxW    = $clog2(WINDOW);
  localparam int unsigned MidRank = WINDOW / 2;

  logic signed [SAMPLE_BITS-1:0] window_q [WINDOW];
  logic        [IdxW-1:0]        slot_q, slot_d;
  logic        [IdxW-1:0]        idx_q;
  logic signed [SAMPLE_BITS-1:0] cand;
  logic        [WINDOW-1:0]      ahead;
  logic        [IdxW-1:0]        rank;
  logic signed [SAMPLE_BITS-1:0] found_q;
  logic signed [SAMPLE_BITS-1:0] median_q;

  assign cand            = window_q[idx_q];
  assign sts_o.scan_last = (idx_q == IdxW'(WINDOW - 1));
  assign median_o        = median_q;

  // entry j sorts before the candidate; ties broken by slot number
  always_comb begin
    for (int unsigned j = 0; j < WINDOW; j++) begin
      ahead[j] = (IdxW'(j) != idx_q) &&
                 ((window_q[j] < cand) ||
                  ((window_q[j] == cand) && (IdxW'(j) < idx_q)));
    end
  end

  always_comb begin
    rank = '0;
    for (int unsigned j = 0; j < WINDOW; j++) begin
      rank = rank + IdxW'(ahead[j]);
    end
  end

  always_comb begin
    slot_d = slot_q + IdxW'(1);
    if (slot_q == IdxW'(WINDOW - 1)) begin
      slot_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < WINDOW; k++) begin
        window_q[k] <= '0;
      end
      slot_q <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.wr_en) begin
        window_q[slot_q] <= sample_i;
        slot_q           <= slot_d;
        idx_q            <= '0;
      end else if (cmd_i.scan_en) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en && (rank == IdxW'(MidRank))) begin
      found_q <= cand;
    end
    if (cmd_i.publish) begin
      median_q <= found_q;
    end
  end

endmodule

@@ design/rmf_checker.sv @@
// port-level checks for the running median filter
// bound to running_median_filter_unit; no package dependency
module rmf_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] median_i
);
  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // requests accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != 2'd0))
    else $error("output without a pending request");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 2'd2) |-> !in_ready_i)
    else $error("input taken with two requests in flight");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input ready right after accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(median_i)))
    else $error("stalled output changed");

endmodule

bind running_median_filter_unit rmf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_rmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .median_i    (out_o.median)
);
